@@ rtl/battery_cell_monitor_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the battery cell monitor core
// ---------------------------------------------------------------------------
`ifndef BATTERY_CELL_MONITOR_CORE_MACROS_SVH
`define BATTERY_CELL_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define BCM_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is low.
`define BCM_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define BCM_ASSERT_NXT_ALWAYS(label, ck, ante, cons, msg) \
  label: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bcm_pkg.sv @@
// ---------------------------------------------------------------------------
// bcm_pkg
// Widths, register codes, constants and shared types of the cell monitor.
// ---------------------------------------------------------------------------
package bcm_pkg;

  localparam int MV_W      = 16;
  localparam int CUR_W     = 16;
  localparam int RES_W     = 10;
  localparam int CNT_OUT_W = 4;
  localparam int WIN_W     = 20;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_CELLS_DEF = 10;

  // I*R drop: signed product, then divide its magnitude by 1000 through a
  // reciprocal multiply. |I*R| < 2^25, so a 35-bit shift is exact.
  localparam int     IR_DIVISOR  = 1000;
  localparam int     PROD_W      = CUR_W + RES_W + 1;
  localparam int     MAG_W       = PROD_W - 2;
  localparam int     RECIP_SHIFT = MAG_W + 10;
  localparam int     RECIP_W     = 26;
  localparam int     RP_W        = MAG_W + RECIP_W;
  localparam longint RECIP_K     =
    ((64'd1 << RECIP_SHIFT) + IR_DIVISOR - 1) / IR_DIVISOR;

  localparam int Q_DEPTH = 2;

  localparam logic [MV_W-1:0]      MV_ALL_ONES       = 16'hFFFF;
  localparam logic [CNT_OUT_W-1:0] EXPECTED_CELLS_RST = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_THRESHOLD = 3'd0,
    CFG_CELL_MIN         = 3'd1,
    CFG_CELL_MAX         = 3'd2,
    CFG_RESUME           = 3'd3,
    CFG_WINDOW_MARGIN    = 3'd4,
    CFG_EXPECTED_CELLS   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [MV_W-1:0]      detect_threshold_mv;
    logic [MV_W-1:0]      cell_min_mv;
    logic [MV_W-1:0]      cell_max_mv;
    logic [MV_W-1:0]      resume_mv;
    logic [MV_W-1:0]      window_margin_mv;
    logic [CNT_OUT_W-1:0] expected_cells;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0] comp_mv;
    logic            present;
    logic            last;
  } cell_item_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_stat_t;

endpackage

@@ rtl/bcm_if.sv @@
// ---------------------------------------------------------------------------
// bcm_if
// Valid/ready channels for cell samples and monitor results.
// ---------------------------------------------------------------------------
interface bcm_in_if;
  import bcm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MV_W-1:0]         raw_cell_mv;
  logic signed [CUR_W-1:0] gauge_current_ma;
  logic [RES_W-1:0]        interconnect_mohm;
  logic                    last_cell;

  modport source (output valid, raw_cell_mv, gauge_current_ma, interconnect_mohm,
                  last_cell, input ready);
  modport sink   (input valid, raw_cell_mv, gauge_current_ma, interconnect_mohm,
                  last_cell, output ready);
endinterface

interface bcm_out_if;
  import bcm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MV_W-1:0]      compensated_mv;
  logic                 summary_valid;
  logic [MV_W-1:0]      min_cell_mv;
  logic [MV_W-1:0]      max_cell_mv;
  logic [MV_W-1:0]      spread_mv;
  logic [CNT_OUT_W-1:0] cells_present;
  logic [WIN_W-1:0]     window_low_mv;
  logic [WIN_W-1:0]     window_high_mv;
  logic                 overvoltage;
  logic                 cell_count_error;
  logic                 undervoltage;
  logic                 no_cells;

  modport source (output valid, compensated_mv, summary_valid, min_cell_mv, max_cell_mv,
                  spread_mv, cells_present, window_low_mv, window_high_mv, overvoltage,
                  cell_count_error, undervoltage, no_cells, input ready);
  modport sink   (input valid, compensated_mv, summary_valid, min_cell_mv, max_cell_mv,
                  spread_mv, cells_present, window_low_mv, window_high_mv, overvoltage,
                  cell_count_error, undervoltage, no_cells, output ready);
endinterface

@@ rtl/battery_cell_monitor_core.sv @@
// ---------------------------------------------------------------------------
// battery_cell_monitor_core
// IR-compensated cell voltages with per-scan min/max, window and pack flags.
// ---------------------------------------------------------------------------
//
//   channel  | dir | handshake       | carries
//   ---------+-----+-----------------+--------------------------------------
//   in_ch    | in  | valid / ready   | raw voltage, gauge current, R, last
//   out_ch   | out | valid / ready   | compensated voltage and scan summary
//   cfg_*    | in  | write enable    | index 0..5, 16-bit write data
//
// Sustains one transaction per cycle in each direction while the output is
// not stalled; a sample passes two multiplier stages (I*R, then the
// reciprocal of 1000), one queue entry, and the result output register.
// Reset is synchronous, active low; it clears pipeline, queue and scan state
// and loads the register defaults. No clearing pass follows reset.
// A stalled output holds its result while the 2-entry queue and the front
// stages keep taking transactions until they fill.
// ---------------------------------------------------------------------------
module battery_cell_monitor_core #(
  parameter int MAX_CELLS = bcm_pkg::MAX_CELLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bcm_in_if.sink                        in_ch,
  bcm_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [bcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcm_pkg::MV_W-1:0]      cfg_wdata
);
  import bcm_pkg::*;

  cfg_t       cfg_r;
  cell_item_t push_item;
  logic       push_valid;
  cell_item_t pop_item;
  logic       pop;
  q_stat_t    q_stat;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_threshold_mv <= '0;
      cfg_r.cell_min_mv         <= '0;
      cfg_r.cell_max_mv         <= MV_ALL_ONES;
      cfg_r.resume_mv           <= '0;
      cfg_r.window_margin_mv    <= '0;
      cfg_r.expected_cells      <= EXPECTED_CELLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DETECT_THRESHOLD: cfg_r.detect_threshold_mv <= cfg_wdata;
        CFG_CELL_MIN:         cfg_r.cell_min_mv         <= cfg_wdata;
        CFG_CELL_MAX:         cfg_r.cell_max_mv         <= cfg_wdata;
        CFG_RESUME:           cfg_r.resume_mv           <= cfg_wdata;
        CFG_WINDOW_MARGIN:    cfg_r.window_margin_mv    <= cfg_wdata;
        CFG_EXPECTED_CELLS:   cfg_r.expected_cells      <= cfg_wdata[CNT_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: compensate and classify each sample against the detect threshold.
  bcm_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ch               (in_ch),
    .detect_threshold_mv (cfg_r.detect_threshold_mv),
    .push_item           (push_item),
    .push_valid          (push_valid),
    .q_stat              (q_stat)
  );

  // Queue: decouple the front pipeline from a stalled output.
  bcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (push_item),
    .push_valid (push_valid),
    .pop_item   (pop_item),
    .pop        (pop),
    .q_stat     (q_stat)
  );

  // Back: track the scan and register one result per transaction.
  bcm_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .item   (pop_item),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ rtl/bcm_front.sv @@
// ---------------------------------------------------------------------------
// bcm_front
// Two-stage IR compensation and presence classification of cell samples.
// ---------------------------------------------------------------------------
module bcm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  bcm_in_if.sink                    in_ch,
  input  logic [bcm_pkg::MV_W-1:0]  detect_threshold_mv,
  output bcm_pkg::cell_item_t       push_item,
  output logic                      push_valid,
  input  bcm_pkg::q_stat_t          q_stat
);
  import bcm_pkg::*;

  logic                     s1_valid_r;
  logic signed [PROD_W-1:0] s1_prod_r;
  logic [MV_W-1:0]          s1_raw_r;
  logic                     s1_last_r;

  logic                     s2_valid_r;
  logic [MV_W-1:0]          s2_quot_r;
  logic                     s2_neg_r;
  logic [MV_W-1:0]          s2_raw_r;
  logic                     s2_last_r;

  logic                     s1_ready;
  logic                     s2_ready;
  logic signed [CUR_W-1:0]  cur_s;
  logic signed [RES_W:0]    res_s;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [MAG_W-1:0]         mag;
  logic [RP_W-1:0]          rp;
  logic [MV_W-1:0]          drop;
  logic [MV_W-1:0]          comp;

  assign s2_ready    = !s2_valid_r || q_stat.not_full;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ch.ready = s1_ready;

  always_comb begin
    cur_s    = in_ch.gauge_current_ma;
    res_s    = $signed({1'b0, in_ch.interconnect_mohm});
    prod_nxt = PROD_W'(cur_s) * PROD_W'(res_s);
    // Divide the magnitude so the quotient truncates toward zero.
    mag      = MAG_W'(s1_prod_r[PROD_W-1] ? -s1_prod_r : s1_prod_r);
    rp       = RP_W'(mag) * RP_W'(RECIP_K);
    drop     = s2_neg_r ? -s2_quot_r : s2_quot_r;
    comp     = s2_raw_r - drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_prod_r <= prod_nxt;
      s1_raw_r  <= in_ch.raw_cell_mv;
      s1_last_r <= in_ch.last_cell;
    end
    if (s2_ready && s1_valid_r) begin
      s2_quot_r <= rp[RECIP_SHIFT +: MV_W];
      s2_neg_r  <= s1_prod_r[PROD_W-1];
      s2_raw_r  <= s1_raw_r;
      s2_last_r <= s1_last_r;
    end
  end

  assign push_valid        = s2_valid_r;
  assign push_item.comp_mv = comp;
  assign push_item.present = comp > detect_threshold_mv;
  assign push_item.last    = s2_last_r;

endmodule

@@ rtl/bcm_queue.sv @@
// ---------------------------------------------------------------------------
// bcm_queue
// Short FIFO of classified cells between the front and back parts.
// ---------------------------------------------------------------------------
module bcm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  bcm_pkg::cell_item_t push_item,
  input  logic                push_valid,
  output bcm_pkg::cell_item_t pop_item,
  input  logic                pop,
  output bcm_pkg::q_stat_t    q_stat
);
  import bcm_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cell_item_t       entry_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_en;
  logic             pop_en;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_stat.not_full  = count_r != CNT_W'(Q_DEPTH);
  assign q_stat.not_empty = count_r != '0;
  assign push_en          = push_valid && q_stat.not_full;
  assign pop_en           = pop && q_stat.not_empty;
  assign pop_item         = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop_en) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push_en, pop_en})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/bcm_back.sv @@
// ---------------------------------------------------------------------------
// bcm_back
// Scan tracking, summary and pack flags, and the result output register.
// ---------------------------------------------------------------------------
module bcm_back #(
  parameter int MAX_CELLS = bcm_pkg::MAX_CELLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bcm_pkg::cfg_t       cfg,
  input  bcm_pkg::cell_item_t item,
  input  bcm_pkg::q_stat_t    q_stat,
  output logic                pop,
  bcm_out_if.source           out_ch
);
  import bcm_pkg::*;

  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  typedef struct packed {
    logic [MV_W-1:0]      compensated_mv;
    logic                 summary_valid;
    logic [MV_W-1:0]      min_cell_mv;
    logic [MV_W-1:0]      max_cell_mv;
    logic [MV_W-1:0]      spread_mv;
    logic [CNT_OUT_W-1:0] cells_present;
    logic [WIN_W-1:0]     window_low_mv;
    logic [WIN_W-1:0]     window_high_mv;
    logic                 overvoltage;
    logic                 cell_count_error;
    logic                 undervoltage;
    logic                 no_cells;
  } res_t;

  logic [MV_W-1:0]      run_min_r;
  logic [MV_W-1:0]      run_max_r;
  logic [CNT_W-1:0]     run_cnt_r;
  logic                 ov_r;
  logic                 out_valid_r;
  res_t                 res_r;

  logic [CNT_W-1:0]     cnt_upd;
  logic [MV_W-1:0]      min_upd;
  logic [MV_W-1:0]      max_upd;
  logic [CNT_OUT_W-1:0] cnt4;
  logic [MV_W-1:0]      mn;
  logic [MV_W-1:0]      mx;
  logic                 ov_nxt;
  res_t                 res_nxt;

  assign pop = q_stat.not_empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    cnt_upd = run_cnt_r;
    min_upd = run_min_r;
    max_upd = run_max_r;
    if (item.present) begin
      if (run_cnt_r < CNT_W'(MAX_CELLS)) begin
        cnt_upd = run_cnt_r + 1'b1;
      end
      if (item.comp_mv < run_min_r) begin
        min_upd = item.comp_mv;
      end
      if (item.comp_mv > run_max_r) begin
        max_upd = item.comp_mv;
      end
    end

    cnt4 = CNT_OUT_W'(cnt_upd);
    mn   = (cnt4 == '0) ? '0 : min_upd;
    mx   = (cnt4 == '0) ? '0 : max_upd;

    if (mx > cfg.cell_max_mv) begin
      ov_nxt = 1'b1;
    end else if (mx < cfg.resume_mv) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end

    res_nxt                = '0;
    res_nxt.compensated_mv = item.comp_mv;
    if (item.last) begin
      res_nxt.summary_valid    = 1'b1;
      res_nxt.min_cell_mv      = mn;
      res_nxt.max_cell_mv      = mx;
      res_nxt.spread_mv        = mx - mn;
      res_nxt.cells_present    = cnt4;
      res_nxt.window_low_mv    = WIN_W'(cnt4) * WIN_W'(cfg.cell_min_mv);
      res_nxt.window_high_mv   = WIN_W'(cnt4) * WIN_W'(cfg.cell_max_mv)
                                 + WIN_W'(cfg.window_margin_mv);
      res_nxt.overvoltage      = ov_nxt;
      res_nxt.cell_count_error = cnt4 != cfg.expected_cells;
      res_nxt.undervoltage     = mn <= cfg.cell_min_mv;
      res_nxt.no_cells         = cnt4 == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_min_r   <= MV_ALL_ONES;
      run_max_r   <= '0;
      run_cnt_r   <= '0;
      ov_r        <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
      if (item.last) begin
        // Close the scan: drop the running state, keep the flag.
        run_min_r <= MV_ALL_ONES;
        run_max_r <= '0;
        run_cnt_r <= '0;
        ov_r      <= ov_nxt;
      end else begin
        run_min_r <= min_upd;
        run_max_r <= max_upd;
        run_cnt_r <= cnt_upd;
      end
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.compensated_mv   = res_r.compensated_mv;
  assign out_ch.summary_valid    = res_r.summary_valid;
  assign out_ch.min_cell_mv      = res_r.min_cell_mv;
  assign out_ch.max_cell_mv      = res_r.max_cell_mv;
  assign out_ch.spread_mv        = res_r.spread_mv;
  assign out_ch.cells_present    = res_r.cells_present;
  assign out_ch.window_low_mv    = res_r.window_low_mv;
  assign out_ch.window_high_mv   = res_r.window_high_mv;
  assign out_ch.overvoltage      = res_r.overvoltage;
  assign out_ch.cell_count_error = res_r.cell_count_error;
  assign out_ch.undervoltage     = res_r.undervoltage;
  assign out_ch.no_cells         = res_r.no_cells;

endmodule

@@ rtl/bcm_checker.sv @@
// ---------------------------------------------------------------------------
// bcm_checker
// Port-level assertions on the result channel of the cell monitor.
// ---------------------------------------------------------------------------
`include "battery_cell_monitor_core_macros.svh"

module bcm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              summary_valid,
  input logic [bcm_pkg::MV_W-1:0]          min_cell_mv,
  input logic [bcm_pkg::MV_W-1:0]          max_cell_mv,
  input logic [bcm_pkg::MV_W-1:0]          spread_mv,
  input logic [bcm_pkg::CNT_OUT_W-1:0]     cells_present,
  input logic [bcm_pkg::WIN_W-1:0]         window_low_mv,
  input logic [bcm_pkg::WIN_W-1:0]         window_high_mv,
  input logic                              overvoltage,
  input logic                              cell_count_error,
  input logic                              undervoltage,
  input logic                              no_cells
);
  import bcm_pkg::*;

  logic mid_result;
  logic scan_result;
  logic mid_fields_zero;
  logic summary_consistent;

  assign mid_result  = out_valid && !summary_valid;
  assign scan_result = out_valid && summary_valid;

  assign mid_fields_zero = (min_cell_mv == '0) && (max_cell_mv == '0) && (spread_mv == '0)
                           && (cells_present == '0) && (window_low_mv == '0)
                           && (window_high_mv == '0) && !overvoltage && !cell_count_error
                           && !undervoltage && !no_cells;

  assign summary_consistent = (spread_mv == MV_W'(max_cell_mv - min_cell_mv))
                              && (no_cells == (cells_present == '0))
                              && (!no_cells || (undervoltage && (max_cell_mv == '0)));

  `BCM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")

  `BCM_ASSERT_NXT_ALWAYS(a_rst_idle, clk, !rst_n, !out_valid, "result valid after reset")

  `BCM_ASSERT_IMP(a_mid_zero, clk, rst_n, mid_result, mid_fields_zero, "mid-scan summary")

  `BCM_ASSERT_IMP(a_summary_sane, clk, rst_n, scan_result, summary_consistent, "bad summary")

endmodule

bind battery_cell_monitor_core bcm_checker u_bcm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .summary_valid    (out_ch.summary_valid),
  .min_cell_mv      (out_ch.min_cell_mv),
  .max_cell_mv      (out_ch.max_cell_mv),
  .spread_mv        (out_ch.spread_mv),
  .cells_present    (out_ch.cells_present),
  .window_low_mv    (out_ch.window_low_mv),
  .window_high_mv   (out_ch.window_high_mv),
  .overvoltage      (out_ch.overvoltage),
  .cell_count_error (out_ch.cell_count_error),
  .undervoltage     (out_ch.undervoltage),
  .no_cells         (out_ch.no_cells)
);

@@ verif/bcm_tb_pkg.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bcm_tb_pkg
// Transaction types and the scan scoreboard for the cell monitor bench. The
// scoreboard keeps its own register copy and scan state, predicts the result
// of each accepted cell sample and compares results in order.
// ---------------------------------------------------------------------------
package bcm_tb_pkg;
  import bcm_pkg::*;

  typedef struct packed {
    logic [MV_W-1:0]  raw_mv;
    logic [CUR_W-1:0] current_ma;
    logic [RES_W-1:0] res_mohm;
    logic             last;
  } cell_sample_t;

  typedef struct packed {
    logic [MV_W-1:0]      compensated_mv;
    logic                 summary_valid;
    logic [MV_W-1:0]      min_cell_mv;
    logic [MV_W-1:0]      max_cell_mv;
    logic [MV_W-1:0]      spread_mv;
    logic [CNT_OUT_W-1:0] cells_present;
    logic [WIN_W-1:0]     window_low_mv;
    logic [WIN_W-1:0]     window_high_mv;
    logic                 overvoltage;
    logic                 cell_count_error;
    logic                 undervoltage;
    logic                 no_cells;
  } cell_result_t;

  // One write value per register, indexed by cfg_idx_t.
  typedef logic [CFG_EXPECTED_CELLS:0][MV_W-1:0] reg_set_t;

  class cell_scan_scoreboard;
    cfg_t                 regs;
    logic [MV_W-1:0]      scan_min;
    logic [MV_W-1:0]      scan_max;
    logic [CNT_OUT_W-1:0] scan_count;
    logic                 ov_flag;
    cell_result_t         pending_q[$];
    int unsigned          mismatches;

    function new();
      regs.detect_threshold_mv = '0;
      regs.cell_min_mv         = '0;
      regs.cell_max_mv         = MV_ALL_ONES;
      regs.resume_mv           = '0;
      regs.window_margin_mv    = '0;
      regs.expected_cells      = EXPECTED_CELLS_RST;
      ov_flag    = 1'b0;
      mismatches = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      scan_min   = MV_ALL_ONES;
      scan_max   = '0;
      scan_count = '0;
    endfunction

    function void load_reg(cfg_idx_t idx, logic [MV_W-1:0] value);
      case (idx)
        CFG_DETECT_THRESHOLD: regs.detect_threshold_mv = value;
        CFG_CELL_MIN:         regs.cell_min_mv = value;
        CFG_CELL_MAX:         regs.cell_max_mv = value;
        CFG_RESUME:           regs.resume_mv = value;
        CFG_WINDOW_MARGIN:    regs.window_margin_mv = value;
        CFG_EXPECTED_CELLS:   regs.expected_cells = value[CNT_OUT_W-1:0];
        default: ;
      endcase
    endfunction

    // v - (I*R)/1000, quotient truncated toward zero, wrapped to 16 bits
    function logic [MV_W-1:0] ir_compensate(cell_sample_t s);
      int drop;
      drop = (int'($signed(s.current_ma)) * int'({1'b0, s.res_mohm})) / IR_DIVISOR;
      return s.raw_mv - drop[MV_W-1:0];
    endfunction

    function void note_sample(cell_sample_t s);
      cell_result_t         want;
      logic [MV_W-1:0]      comp;
      logic [MV_W-1:0]      mn;
      logic [MV_W-1:0]      mx;
      logic [CNT_OUT_W-1:0] cnt;
      comp = ir_compensate(s);
      if (comp > regs.detect_threshold_mv) begin
        if (scan_count < MAX_CELLS_DEF) scan_count++;
        if (comp < scan_min) scan_min = comp;
        if (comp > scan_max) scan_max = comp;
      end
      want = '0;
      want.compensated_mv = comp;
      if (s.last) begin
        cnt = scan_count;
        mn  = (cnt == 0) ? '0 : scan_min;
        mx  = (cnt == 0) ? '0 : scan_max;
        // hysteresis: set above the max level, clear below resume
        if (mx > regs.cell_max_mv) ov_flag = 1'b1;
        else if (mx < regs.resume_mv) ov_flag = 1'b0;
        want.summary_valid    = 1'b1;
        want.min_cell_mv      = mn;
        want.max_cell_mv      = mx;
        want.spread_mv        = mx - mn;
        want.cells_present    = cnt;
        want.window_low_mv    = WIN_W'(int'(cnt) * int'(regs.cell_min_mv));
        want.window_high_mv   = WIN_W'(int'(cnt) * int'(regs.cell_max_mv)
                                       + int'(regs.window_margin_mv));
        want.overvoltage      = ov_flag;
        want.cell_count_error = (cnt != regs.expected_cells);
        want.undervoltage     = (mn <= regs.cell_min_mv);
        want.no_cells         = (cnt == 0);
        clear_scan();
      end
      pending_q.push_back(want);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t want;
      if (pending_q.size() == 0) begin
        $error("result transaction with no prediction pending");
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      check_field("compensated_mv", want.compensated_mv, got.compensated_mv);
      check_field("summary_valid", want.summary_valid, got.summary_valid);
      check_field("min_cell_mv", want.min_cell_mv, got.min_cell_mv);
      check_field("max_cell_mv", want.max_cell_mv, got.max_cell_mv);
      check_field("spread_mv", want.spread_mv, got.spread_mv);
      check_field("cells_present", want.cells_present, got.cells_present);
      check_field("window_low_mv", want.window_low_mv, got.window_low_mv);
      check_field("window_high_mv", want.window_high_mv, got.window_high_mv);
      check_field("overvoltage", want.overvoltage, got.overvoltage);
      check_field("cell_count_error", want.cell_count_error, got.cell_count_error);
      check_field("undervoltage", want.undervoltage, got.undervoltage);
      check_field("no_cells", want.no_cells, got.no_cells);
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction
  endclass

endpackage

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Bench for battery_cell_monitor_core. Drives cell samples and register
// writes, predicts every result with the scan scoreboard and checks each
// result transaction in order, under several sender and receiver traffic
// patterns and one long output hold-off.
// ---------------------------------------------------------------------------
module tb;
  import bcm_pkg::*;
  import bcm_tb_pkg::*;

  typedef enum int {
    TRAFFIC_FREE,
    TRAFFIC_SENDER_GAPS,
    TRAFFIC_SINK_STALLS,
    TRAFFIC_BOTH
  } traffic_mode_t;

  typedef enum int {
    REGS_TYPICAL,
    REGS_ZERO,
    REGS_ONES,
    REGS_ANY
  } regs_kind_t;

  localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 8;     // pipeline latency plus margin
  localparam int unsigned PHASE_ITEMS   = 160;
  localparam int unsigned PRESSURE_ITEMS = 40;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MV_W-1:0]      cfg_wdata;

  bcm_in_if  in_ch ();
  bcm_out_if out_ch ();

  battery_cell_monitor_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cell_scan_scoreboard sb;

  // Traffic knobs, percent of cycles spent idle / stalled.
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Monitor: feed accepted samples to the predictor, check accepted results.
  // Both are sampled at the edge, before any bench update of that step.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    cell_sample_t s;
    cell_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        s.raw_mv     = in_ch.raw_cell_mv;
        s.current_ma = in_ch.gauge_current_ma;
        s.res_mohm   = in_ch.interconnect_mohm;
        s.last       = in_ch.last_cell;
        sb.note_sample(s);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.compensated_mv   = out_ch.compensated_mv;
        got.summary_valid    = out_ch.summary_valid;
        got.min_cell_mv      = out_ch.min_cell_mv;
        got.max_cell_mv      = out_ch.max_cell_mv;
        got.spread_mv        = out_ch.spread_mv;
        got.cells_present    = out_ch.cells_present;
        got.window_low_mv    = out_ch.window_low_mv;
        got.window_high_mv   = out_ch.window_high_mv;
        got.overvoltage      = out_ch.overvoltage;
        got.cell_count_error = out_ch.cell_count_error;
        got.undervoltage     = out_ch.undervoltage;
        got.no_cells         = out_ch.no_cells;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random stalls per the traffic knob; on request, hold off for a
  // long stretch counted here so the block fills and stalls its input.
  // -------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  task automatic set_traffic(traffic_mode_t mode);
    case (mode)
      TRAFFIC_FREE:        begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      TRAFFIC_SENDER_GAPS: begin snd_idle_pct = 68; rcv_stall_pct = 0;  end
      TRAFFIC_SINK_STALLS: begin snd_idle_pct = 0;  rcv_stall_pct = 68; end
      default:             begin snd_idle_pct = 38; rcv_stall_pct = 38; end
    endcase
  endtask

  // Offer one sample and hold it until accepted. Valid stays high on return;
  // the next call or drain_results decides what follows in that same step.
  task automatic send_sample(cell_sample_t s);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.raw_cell_mv       <= s.raw_mv;
    in_ch.gauge_current_ma  <= s.current_ma;
    in_ch.interconnect_mohm <= s.res_mohm;
    in_ch.last_cell         <= s.last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers on back-to-back cycles; only call while idle.
  task automatic program_regs(reg_set_t vals);
    cfg_idx_t idx;
    idx = CFG_DETECT_THRESHOLD;
    forever begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[idx];
      @(posedge clk);
      sb.load_reg(idx, vals[idx]);
      if (idx == CFG_EXPECTED_CELLS) break;
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  function automatic cell_sample_t mk_sample(logic [MV_W-1:0] raw, int cur,
                                             int unsigned res, bit last);
    cell_sample_t s;
    s.raw_mv     = raw;
    s.current_ma = CUR_W'(cur);
    s.res_mohm   = RES_W'(res);
    s.last       = last;
    return s;
  endfunction

  function automatic reg_set_t pick_regs(regs_kind_t kind);
    reg_set_t vals;
    case (kind)
      REGS_ZERO: vals = '0;
      REGS_ONES: vals = '1;
      REGS_ANY: begin
        foreach (vals[i]) vals[i] = MV_W'($urandom);
      end
      default: begin
        vals[CFG_DETECT_THRESHOLD] = MV_W'($urandom_range(2500));
        vals[CFG_CELL_MIN]         = MV_W'($urandom_range(3300, 2500));
        vals[CFG_CELL_MAX]         = MV_W'($urandom_range(4300, 4000));
        vals[CFG_RESUME]           = vals[CFG_CELL_MAX] - MV_W'($urandom_range(300));
        vals[CFG_WINDOW_MARGIN]    = MV_W'($urandom_range(2000));
        // now and then an expected count above the cell limit
        vals[CFG_EXPECTED_CELLS]   = ($urandom_range(7) == 0) ? MV_W'(15)
                                                              : MV_W'($urandom_range(10));
      end
    endcase
    return vals;
  endfunction

  // Mostly voltages near one of the configured levels with a small IR drop,
  // plus full-range values and the rails.
  function automatic cell_sample_t pick_sample(reg_set_t vals, bit last);
    cell_sample_t s;
    logic [MV_W-1:0] base;
    case ($urandom_range(3))
      0:       base = vals[CFG_DETECT_THRESHOLD];
      1:       base = vals[CFG_CELL_MIN];
      2:       base = vals[CFG_CELL_MAX];
      default: base = vals[CFG_RESUME];
    endcase
    case ($urandom_range(9))
      6, 7:    s.raw_mv = MV_W'($urandom);
      8:       s.raw_mv = '0;
      9:       s.raw_mv = '1;
      default: s.raw_mv = base + MV_W'($urandom_range(400)) - MV_W'(200);
    endcase
    if ($urandom_range(9) < 6) begin
      s.current_ma = CUR_W'($urandom_range(4000)) - CUR_W'(2000);
      s.res_mohm   = RES_W'($urandom_range(50));
    end else begin
      s.current_ma = CUR_W'($urandom);
      s.res_mohm   = RES_W'($urandom_range(1023));
    end
    s.last = last;
    // noise: a fully random sample, end-of-scan marker included
    if ($urandom_range(9) == 0) s = cell_sample_t'({$urandom, $urandom});
    return s;
  endfunction

  // Scans of random length, some longer than the cell limit; noise samples may carry their own end-of-scan marker.
  task automatic run_scans(int unsigned n_items, reg_set_t vals);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(MAX_CELLS_DEF + 2, 1);
      for (int unsigned k = 0; k < len; k++) begin
        send_sample(pick_sample(vals, k == len - 1));
        sent++;
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    reg_set_t vals;
    sb = new();
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_DETECT_THRESHOLD;
    cfg_wdata               <= '0;
    in_ch.valid             <= 1'b0;
    in_ch.raw_cell_mv       <= '0;
    in_ch.gauge_current_ma  <= '0;
    in_ch.interconnect_mohm <= '0;
    in_ch.last_cell         <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values. An empty scan: all summary values
    // zero, count error, undervoltage and no_cells raised.
    set_traffic(TRAFFIC_FREE);
    send_sample(mk_sample(16'd0, 0, 0, 1'b1));
    // Eleven present cells: the count saturates at ten, min and max keep
    // tracking. Covers the current and resistance rails, both wrap
    // directions and truncation of small negative drops toward zero.
    send_sample(mk_sample(16'hFFFF, 0, 0, 1'b0));
    send_sample(mk_sample(16'd1, 0, 0, 1'b0));
    send_sample(mk_sample(16'hFFFF, 32767, 1023, 1'b0));
    send_sample(mk_sample(16'd0, -32768, 1023, 1'b0));
    send_sample(mk_sample(16'd5, 32767, 1023, 1'b0));
    send_sample(mk_sample(16'd1, 1, 999, 1'b0));
    send_sample(mk_sample(16'd10, -1, 1, 1'b0));
    send_sample(mk_sample(16'd10, -1000, 1, 1'b0));
    send_sample(mk_sample(16'd10, 1000, 1, 1'b0));
    send_sample(mk_sample(16'd1234, -1, 1023, 1'b0));
    send_sample(mk_sample(16'd0, 0, 1023, 1'b0));
    send_sample(mk_sample(16'h8000, -12345, 512, 1'b1));
    send_sample(mk_sample(16'd0, -32768, 0, 1'b0));
    send_sample(mk_sample(16'hFFFF, -32768, 1023, 1'b1));
    drain_results();

    // Directed overvoltage hysteresis: set above max, hold between resume
    // and max, clear below resume. Undervoltage at exactly the minimum, and
    // a cell at exactly the threshold that does not count.
    vals[CFG_DETECT_THRESHOLD] = 16'd100;
    vals[CFG_CELL_MIN]         = 16'd3000;
    vals[CFG_CELL_MAX]         = 16'd4200;
    vals[CFG_RESUME]           = 16'd4000;
    vals[CFG_WINDOW_MARGIN]    = 16'd500;
    vals[CFG_EXPECTED_CELLS]   = 16'd2;
    program_regs(vals);
    send_sample(mk_sample(16'd3500, 0, 0, 1'b0));
    send_sample(mk_sample(16'd4300, 0, 0, 1'b1));
    send_sample(mk_sample(16'd3500, 0, 0, 1'b0));
    send_sample(mk_sample(16'd4100, 0, 0, 1'b1));
    send_sample(mk_sample(16'd3000, 0, 0, 1'b0));
    send_sample(mk_sample(16'd3900, 0, 0, 1'b1));
    send_sample(mk_sample(16'd100, 0, 0, 1'b0));
    send_sample(mk_sample(16'd101, 0, 0, 1'b1));
    drain_results();

    // Random phases: every traffic pattern twice, with typical register
    // sets and the all-zero, all-one and fully random extremes.
    for (int p = 0; p < 8; p++) begin
      vals = pick_regs((p == 2) ? REGS_ZERO : (p == 5) ? REGS_ONES :
                       (p == 6) ? REGS_ANY : REGS_TYPICAL);
      program_regs(vals);
      set_traffic(traffic_mode_t'(p % 4));
      run_scans(PHASE_ITEMS, vals);
      drain_results();
    end

    // Back-pressure: hold the receiver off while the sender keeps offering.
    vals = pick_regs(REGS_TYPICAL);
    program_regs(vals);
    set_traffic(TRAFFIC_FREE);
    hold_req = 1'b1;
    run_scans(PRESSURE_ITEMS, vals);
    drain_results();

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bcm_pkg.sv
rtl/bcm_if.sv
rtl/bcm_front.sv
rtl/bcm_queue.sv
rtl/bcm_back.sv
rtl/battery_cell_monitor_core.sv
rtl/bcm_checker.sv
verif/bcm_tb_pkg.sv
verif/tb.sv
